[hw/rtl/adrb_pkg.sv]
// adrb_pkg: shared types, constants and helpers for the disc/ring blend block
// no dependencies
package adrb_pkg;

  localparam int CanvasWidth  = 4096;
  localparam int CanvasHeight = 4096;

  // squared distance: |dx|,|dy| < 2^30, sum < 2^61
  localparam int SqW    = 62;
  localparam int RootW  = 31;
  localparam int NCells = RootW;
  // width of a cell's digit position
  localparam int PosW   = $clog2(RootW);

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_RADIUS     = 3'd2,
    REG_RING_WIDTH = 3'd3,
    REG_MODE       = 3'd4,
    REG_COLOR      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic       valid;
    logic       draw;
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
    logic [7:0] da;
  } pix_t;

  // one digit of the square root recurrence travelling through the cells
  typedef struct packed {
    pix_t             pix;
    logic [SqW-1:0]   rem;
    logic [RootW-1:0] root;
  } sq_t;

  function automatic logic [7:0] div255(input logic [16:0] v);
    logic [17:0] t;
    logic [18:0] s;
    begin
      t = {1'b0, v} + 18'd128;
      s = {1'b0, t} + {9'd0, t[17:8]};
      div255 = s[15:8];
    end
  endfunction

endpackage

[hw/rtl/antialiased_disc_ring_blend.sv]
// antialiased_disc_ring_blend: top level, anti-aliased disc/ring shading
// depends on adrb_pkg and adrb_sqrt_cell
// throughput one pixel per cycle
// the chain of 31 square root cells sets the latency, each cell one digit
// reset (synchronous, rst_n low) clears all valid flags and loads the
// register reset values; the receiver cannot stall, results are not held
module antialiased_disc_ring_blend (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic [7:0]  in_dest_red,
  input  logic [7:0]  in_dest_green,
  input  logic [7:0]  in_dest_blue,
  input  logic [7:0]  in_dest_alpha,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_strobe,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_pixel_touched
);
  import adrb_pkg::*;

  // configuration registers
  logic signed [28:0] cx_r, cy_r;
  logic [27:0]        rad_r, rw_r;
  logic               mode_r;
  logic [31:0]        col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; rad_r <= '0; rw_r <= 28'd256;
      mode_r <= 1'b0; col_r <= 32'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:   cx_r   <= cfg_data[28:0];
        REG_CENTER_Y:   cy_r   <= cfg_data[28:0];
        REG_RADIUS:     rad_r  <= cfg_data[27:0];
        REG_RING_WIDTH: rw_r   <= cfg_data[27:0];
        REG_MODE:       mode_r <= cfg_data[0];
        REG_COLOR:      col_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // never stalls: a new transaction every cycle
  assign busy = 1'b0;
  logic accept;
  assign accept = start & ~busy;

  // stage 1: offsets from the centre, absolute values
  logic               s1_valid_r;
  pix_t               s1_pix_r;
  logic [29:0]        ax_r, ay_r;
  logic signed [30:0] dx, dy;
  logic               on_canvas;

  always_comb begin
    dx = $signed({7'd0, in_pixel_x, 8'd128}) - 31'(cx_r);
    dy = $signed({7'd0, in_pixel_y, 8'd128}) - 31'(cy_r);
    on_canvas = (32'(in_pixel_x) < CanvasWidth) && (32'(in_pixel_y) < CanvasHeight);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= accept;
    s1_pix_r.valid <= accept;
    // a zero-radius disc draws nothing
    s1_pix_r.draw  <= on_canvas && !(mode_r == 1'b0 && rad_r == '0);
    s1_pix_r.dr <= in_dest_red;
    s1_pix_r.dg <= in_dest_green;
    s1_pix_r.db <= in_dest_blue;
    s1_pix_r.da <= in_dest_alpha;
    ax_r <= dx[30] ? 30'(-dx) : 30'(dx);
    ay_r <= dy[30] ? 30'(-dy) : 30'(dy);
  end

  // stage 2: squares; their sum feeds the first root cell
  logic [59:0] sqx_r, sqy_r;
  pix_t        s2_pix_r;
  logic        s2_valid_r;
  sq_t         chain [NCells+1];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else        s2_valid_r <= s1_valid_r;
    s2_pix_r <= s1_pix_r;
    sqx_r <= ax_r * ax_r;
    sqy_r <= ay_r * ay_r;
  end

  always_comb begin
    chain[0].pix       = s2_pix_r;
    chain[0].pix.valid = s2_valid_r;
    chain[0].rem       = SqW'({1'b0, sqx_r} + {1'b0, sqy_r});
    chain[0].root      = '0;
  end

  // row of root cells, one result bit each, most significant digit first
  for (genvar g = 0; g < NCells; g++) begin : g_cell
    adrb_sqrt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .pos  (PosW'(RootW - 1 - g)),
      .d_in (chain[g]),
      .d_out(chain[g+1])
    );
  end

  // coverage in 1/512 units, clamped
  sq_t                tail;
  logic signed [33:0] cov_raw, diff;
  logic [9:0]         cov;
  assign tail = chain[NCells];

  always_comb begin
    diff = $signed({3'd0, tail.root}) - $signed({6'd0, rad_r});
    if (mode_r == 1'b0) begin
      cov_raw = 34'sd2 * ($signed({6'd0, rad_r}) + 34'sd128 - $signed({3'd0, tail.root}));
    end else begin
      if (diff < 0) diff = -diff;
      cov_raw = $signed({6'd0, rw_r}) + 34'sd256 - 34'sd2 * diff;
    end
    if (cov_raw < 0)           cov = '0;
    else if (cov_raw > 34'sd512) cov = 10'd512;
    else                       cov = cov_raw[9:0];
  end

  logic       s4_valid_r;
  pix_t       s4_pix_r;
  logic [9:0] cov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_valid_r <= 1'b0;
    else        s4_valid_r <= tail.pix.valid;
    s4_pix_r <= tail.pix;
    cov_r    <= cov;
  end

  // effective alpha
  logic [17:0] amul;
  logic [7:0]  a_r;
  pix_t        s5_pix_r;
  logic        s5_valid_r;
  assign amul = cov_r * col_r[7:0] + 18'd256;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_valid_r <= 1'b0;
    else        s5_valid_r <= s4_valid_r;
    s5_pix_r <= s4_pix_r;
    a_r      <= amul[16:9];
  end

  // products for the blend
  logic [16:0] pr_r, pg_r, pb_r, pa_r;
  logic [7:0]  ia;
  pix_t        s6_pix_r;
  logic        s6_valid_r, s6_hit_r;
  assign ia = 8'd255 - a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s6_valid_r <= 1'b0;
    else        s6_valid_r <= s5_valid_r;
    s6_pix_r <= s5_pix_r;
    s6_hit_r <= s5_pix_r.draw && (a_r != 8'd0);
    pr_r <= 17'(col_r[31:24] * a_r) + 17'(s5_pix_r.dr * ia);
    pg_r <= 17'(col_r[23:16] * a_r) + 17'(s5_pix_r.dg * ia);
    pb_r <= 17'(col_r[15:8]  * a_r) + 17'(s5_pix_r.db * ia);
    pa_r <= 17'(8'd255 * a_r)       + 17'(s5_pix_r.da * ia);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= s6_valid_r;
    out_pixel_touched <= s6_hit_r;
    out_red   <= s6_hit_r ? div255(pr_r) : s6_pix_r.dr;
    out_green <= s6_hit_r ? div255(pg_r) : s6_pix_r.dg;
    out_blue  <= s6_hit_r ? div255(pb_r) : s6_pix_r.db;
    out_alpha <= s6_hit_r ? div255(pa_r) : s6_pix_r.da;
  end

  // a valid pixel in the last stage must not be lost at the output
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    s6_valid_r |=> out_strobe) else $error("result lost at output");
  a_touch_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_pixel_touched && !out_strobe |-> 1'b0 || !$past(s6_valid_r))
    else $error("touched without result");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("block stalled");

endmodule

[hw/rtl/adrb_sqrt_cell.sv]
// adrb_sqrt_cell: one restoring square root digit step, registered
// depends on adrb_pkg
module adrb_sqrt_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [adrb_pkg::PosW-1:0] pos,
  input  adrb_pkg::sq_t            d_in,
  output adrb_pkg::sq_t            d_out
);
  import adrb_pkg::*;

  logic [SqW+1:0] trial;
  logic [SqW+1:0] remw;
  sq_t            d_nxt;
  sq_t            d_r;

  // pos is the bit position of this digit, tied off at the instance
  always_comb begin
    d_nxt = d_in;
    // trial = (4*root + 1) << 2*pos, compared against remainder
    trial = (({{(SqW+2-RootW){1'b0}}, d_in.root} << 2) << {pos, 1'b0})
          | ({{(SqW+1){1'b0}}, 1'b1} << {pos, 1'b0});
    remw  = {2'b00, d_in.rem};
    d_nxt.root = d_in.root << 1;
    if (remw >= trial) begin
      d_nxt.rem  = SqW'(remw - trial);
      d_nxt.root = (d_in.root << 1) | {{(RootW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.pix.valid <= 1'b0;
    end else begin
      d_r.pix.valid <= d_nxt.pix.valid;
    end
    d_r.pix.draw <= d_nxt.pix.draw;
    d_r.pix.dr   <= d_nxt.pix.dr;
    d_r.pix.dg   <= d_nxt.pix.dg;
    d_r.pix.db   <= d_nxt.pix.db;
    d_r.pix.da   <= d_nxt.pix.da;
    d_r.rem      <= d_nxt.rem;
    d_r.root     <= d_nxt.root;
  end

  assign d_out = d_r;

endmodule

[dv/tb_antialiased_disc_ring_blend.sv]
// tb_antialiased_disc_ring_blend: self-checking bench for the anti-aliased disc/ring blend
// depends on adrb_pkg and antialiased_disc_ring_blend; drives pixels, checks every blended result
module tb_antialiased_disc_ring_blend;
  timeunit 1ns;
  timeprecision 1ps;
  import adrb_pkg::*;

  localparam int LATENCY    = 38;
  localparam int MAX_CYCLES = 400000;
  localparam logic [2:0] UNUSED_REG = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] in_pixel_x = '0;
  logic [11:0] in_pixel_y = '0;
  logic [7:0]  in_dest_red = '0;
  logic [7:0]  in_dest_green = '0;
  logic [7:0]  in_dest_blue = '0;
  logic [7:0]  in_dest_alpha = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        out_strobe;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_pixel_touched;

  // one blended pixel as seen on the result ports
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       touched;
  } blend_t;

  // one row of the directed table; has_fixed marks a hand-typed expectation
  typedef struct {
    logic [11:0] px;
    logic [11:0] py;
    logic [31:0] dest;
    logic        has_fixed;
    blend_t      fixed;
  } pix_row_t;

  blend_t      blend_queue[$];
  int          n_fail = 0;
  int          n_checked = 0;
  int          n_touched = 0;
  longint      cycle = 0;
  int          idle_pct = 19;

  // shadow copy of the configuration registers
  logic signed [28:0] sh_cx = '0;
  logic signed [28:0] sh_cy = '0;
  logic [27:0]        sh_radius = '0;
  logic [27:0]        sh_ring_w = 28'd256;
  logic               sh_mode = 1'b0;
  logic [31:0]        sh_color = 32'd255;

  antialiased_disc_ring_blend i_dut (
    .clk, .rst_n, .start, .busy,
    .in_pixel_x, .in_pixel_y, .in_dest_red, .in_dest_green, .in_dest_blue, .in_dest_alpha,
    .cfg_we, .cfg_index, .cfg_data,
    .out_strobe, .out_red, .out_green, .out_blue, .out_alpha, .out_pixel_touched
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] root_of(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    begin
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    end
  endfunction

  function automatic logic [7:0] round255(input logic [63:0] v);
    logic [63:0] t;
    begin
      t = v + 128;
      return 8'((t + (t >> 8)) >> 8);
    end
  endfunction

  // coverage and source-over blend of one pixel
  function automatic blend_t shade_pixel(input logic [11:0] px, input logic [11:0] py,
                                         input logic [31:0] dest);
    blend_t res;
    longint dx, dy, rdist, covr, diff;
    logic [63:0] alpha_eff;
    logic [7:0]  srcc[4];
    logic [7:0]  dstc[4];
    begin
      res = {dest, 1'b0};
      dstc = '{dest[31:24], dest[23:16], dest[15:8], dest[7:0]};
      srcc = '{sh_color[31:24], sh_color[23:16], sh_color[15:8], 8'd255};
      if (px >= CanvasWidth || py >= CanvasHeight) return res;
      if (!sh_mode && sh_radius == 0) return res;
      dx = longint'(px) * 256 + 128 - longint'(sh_cx);
      dy = longint'(py) * 256 + 128 - longint'(sh_cy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      rdist = longint'(root_of(64'(dx * dx + dy * dy)));
      if (!sh_mode) begin
        covr = 2 * (longint'(sh_radius) + 128 - rdist);
      end else begin
        diff = rdist - longint'(sh_radius);
        if (diff < 0) diff = -diff;
        covr = longint'(sh_ring_w) + 256 - 2 * diff;
      end
      if (covr < 0) covr = 0;
      if (covr > 512) covr = 512;
      alpha_eff = (64'(covr) * sh_color[7:0] + 256) >> 9;
      if (alpha_eff == 0) return res;
      if (alpha_eff > 255) alpha_eff = 255;
      res.r = round255(srcc[0] * alpha_eff + dstc[0] * (255 - alpha_eff));
      res.g = round255(srcc[1] * alpha_eff + dstc[1] * (255 - alpha_eff));
      res.b = round255(srcc[2] * alpha_eff + dstc[2] * (255 - alpha_eff));
      res.a = round255(srcc[3] * alpha_eff + dstc[3] * (255 - alpha_eff));
      res.touched = 1'b1;
      return res;
    end
  endfunction

  // result monitor: the block cannot be held off, so every strobe is checked at once
  always @(posedge clk) begin
    blend_t want;
    if (rst_n && out_strobe) begin
      if (blend_queue.size() == 0) begin
        $error("result with no pixel outstanding");
        n_fail++;
      end else begin
        want = blend_queue.pop_front();
        n_checked++;
        if (out_pixel_touched) n_touched++;
        if (out_red !== want.r) begin
          $error("out_red expected %0d actual %0d", want.r, out_red); n_fail++;
        end
        if (out_green !== want.g) begin
          $error("out_green expected %0d actual %0d", want.g, out_green); n_fail++;
        end
        if (out_blue !== want.b) begin
          $error("out_blue expected %0d actual %0d", want.b, out_blue); n_fail++;
        end
        if (out_alpha !== want.a) begin
          $error("out_alpha expected %0d actual %0d", want.a, out_alpha); n_fail++;
        end
        if (out_pixel_touched !== want.touched) begin
          $error("out_pixel_touched expected %0d actual %0d", want.touched,
                 out_pixel_touched);
          n_fail++;
        end
      end
    end
  end

  // register write, only ever issued with the pipe drained
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    begin
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      cfg_we <= 1'b0;
      case (idx)
        REG_CENTER_X:   sh_cx = val[28:0];
        REG_CENTER_Y:   sh_cy = val[28:0];
        REG_RADIUS:     sh_radius = val[27:0];
        REG_RING_WIDTH: sh_ring_w = val[27:0];
        REG_MODE:       sh_mode = val[0];
        REG_COLOR:      sh_color = val;
        default: ;
      endcase
      @(posedge clk);
    end
  endtask

  // unused index: must be ignored by the block
  task automatic write_unused(input logic [31:0] val);
    begin
      cfg_we <= 1'b1;
      cfg_index <= UNUSED_REG;
      cfg_data <= val;
      @(posedge clk);
      cfg_we <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_pipe();
    begin
      while (blend_queue.size() != 0) @(posedge clk);
      repeat (LATENCY + 4) @(posedge clk);
    end
  endtask

  // one transaction; optional idle gap beforehand, start held across back-to-back pixels
  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                            input logic [31:0] dest, input bit use_fixed,
                            input blend_t fixed);
    begin
      if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      start <= 1'b1;
      in_pixel_x <= px;
      in_pixel_y <= py;
      {in_dest_red, in_dest_green, in_dest_blue, in_dest_alpha} <= dest;
      @(posedge clk);
      while (busy) @(posedge clk);
      blend_queue.insert(blend_queue.size(), use_fixed ? fixed : shade_pixel(px, py, dest));
    end
  endtask

  task automatic pause_sender();
    begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // random pixel, mostly within the shape's bounding box so some coverage is fractional
  task automatic random_pixel();
    logic [11:0] px, py;
    int cxp, cyp, rp;
    begin
      cxp = sh_cx >>> 8;
      cyp = sh_cy >>> 8;
      rp  = sh_radius >> 8;
      if ($urandom_range(99) < 70) begin
        px = 12'(cxp + $urandom_range(0, 2 * rp + 4) - rp - 2);
        py = 12'(cyp + $urandom_range(0, 2 * rp + 4) - rp - 2);
      end else begin
        px = 12'($urandom());
        py = 12'($urandom());
      end
      send_pixel(px, py, $urandom(), 1'b0, '0);
    end
  endtask

  pix_row_t dir_rows[$];

  initial begin
    blend_t none;
    none = '0;
    // after reset: zero-radius disc, every pixel passes through untouched
    dir_rows.insert(dir_rows.size(),
                    '{12'd0, 12'd0, 32'h00000000, 1'b1, {32'h00000000, 1'b0}});
    dir_rows.insert(dir_rows.size(),
                    '{12'd4095, 12'd4095, 32'hFFFFFFFF, 1'b1, {32'hFFFFFFFF, 1'b0}});
    dir_rows.insert(dir_rows.size(),
                    '{12'd10, 12'd20, 32'h12345678, 1'b1, {32'h12345678, 1'b0}});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_pixel(dir_rows[i].px, dir_rows[i].py, dir_rows[i].dest,
                 dir_rows[i].has_fixed, dir_rows[i].fixed);
    pause_sender();
    drain_pipe();

    // disc at (8,8) radius 5, opaque red: inside, edge, outside, dest extremes
    write_reg(REG_CENTER_X, 32'(8 * 256));
    write_reg(REG_CENTER_Y, 32'(8 * 256));
    write_reg(REG_RADIUS, 32'(5 * 256));
    write_reg(REG_COLOR, 32'hFF0000FF);
    write_unused(32'hDEADBEEF);
    send_pixel(12'd8, 12'd8, 32'h00000000, 1'b1, {32'hFF0000FF, 1'b1});
    send_pixel(12'd7, 12'd7, 32'hFFFFFFFF, 1'b1, {32'hFF0000FF, 1'b1});
    send_pixel(12'd100, 12'd100, 32'hA5A5A5A5, 1'b1, {32'hA5A5A5A5, 1'b0});
    for (int k = 0; k < 8; k++) send_pixel(12'(k + 2), 12'd8, $urandom(), 1'b0, none);
    // zero paint alpha: nothing touched
    pause_sender();
    drain_pipe();
    write_reg(REG_COLOR, 32'h11223300);
    send_pixel(12'd8, 12'd8, 32'h5A5A5A5A, 1'b1, {32'h5A5A5A5A, 1'b0});
    // ring with radius zero, half-alpha paint
    pause_sender();
    drain_pipe();
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_RADIUS, 32'd0);
    write_reg(REG_RING_WIDTH, 32'(3 * 256));
    write_reg(REG_COLOR, 32'h00FF8080);
    for (int k = 0; k < 6; k++) send_pixel(12'(6 + k), 12'd8, $urandom(), 1'b0, none);

    // random phases through several register settings, extremes among them
    for (int ph = 0; ph < 12; ph++) begin
      pause_sender();
      drain_pipe();
      case (ph)
        0: begin
          write_reg(REG_CENTER_X, 32'h0FFFFFFF);          // far positive extreme
          write_reg(REG_CENTER_Y, 32'h10000000);          // most negative
          write_reg(REG_RADIUS, 32'h0FFFFFFF);
          write_reg(REG_RING_WIDTH, 32'h0FFFFFFF);
        end
        1: begin
          write_reg(REG_CENTER_X, 32'(2048 * 256 + 37));
          write_reg(REG_CENTER_Y, 32'(2048 * 256 + 201));
          write_reg(REG_RADIUS, 32'(20 * 256 + 77));
          write_reg(REG_RING_WIDTH, 32'd0);
        end
        2: write_reg(REG_CENTER_X, 32'(-(5 * 256)));
        3: write_reg(REG_COLOR, 32'hFFFFFFFF);
        default: begin
          write_reg(REG_CENTER_X, 32'($urandom_range(0, 4095 * 256)));
          write_reg(REG_CENTER_Y, 32'($urandom_range(0, 4095 * 256)));
          write_reg(REG_RADIUS, 32'($urandom_range(0, 40 * 256)));
          write_reg(REG_RING_WIDTH, 32'($urandom_range(0, 12 * 256)));
          write_reg(REG_COLOR, $urandom());
        end
      endcase
      write_reg(REG_MODE, 32'(ph % 2));
      idle_pct = (ph == 5) ? 0 : 19;           // one stretch at full rate
      for (int k = 0; k < 95; k++) random_pixel();
    end
    pause_sender();
    drain_pipe();

    $display("checked %0d blended pixels, %0d of them touched, across disc and ring phases",
             n_checked, n_touched);
    if (n_fail == 0 && blend_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/adrb_pkg.sv
hw/rtl/adrb_sqrt_cell.sv
hw/rtl/antialiased_disc_ring_blend.sv
dv/tb_antialiased_disc_ring_blend.sv
